[sv/gfps_pkg.sv]
package gfps_pkg;

   // One pixel on the request side.
   typedef struct packed {
      logic [4:0]  column;
      logic [7:0]  row;
      logic [15:0] mask_low;
      logic [15:0] mask_high;
   } req_type;

   // One shaded pixel on the response side.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   // Stage advance strobes handed to each color channel.
   typedef struct packed {
      logic blend;
      logic out;
   } adv_type;

   typedef enum logic [2:0] {
      CSR_START_RED   = 3'd0,
      CSR_START_GREEN = 3'd1,
      CSR_START_BLUE  = 3'd2,
      CSR_END_RED     = 3'd3,
      CSR_END_GREEN   = 3'd4,
      CSR_END_BLUE    = 3'd5,
      CSR_ROT_COS     = 3'd6,
      CSR_ROT_SIN     = 3'd7
   } csr_index_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Blend weight is Q0.16 with one extra bit so that one is exact.
   localparam int          WEIGHT_W   = 17;
   localparam logic [16:0] WEIGHT_ONE = 17'd65536;

   // Gain is Q3.8.
   localparam int          GAIN_W     = 11;
   localparam logic [10:0] GAIN_UNITY = 11'd256;

   localparam int          FEATHER_LAST  = 4;
   localparam int          FEATHER_LIMIT = 1280;

   localparam logic [10:0] GAIN_TABLE [7] = '{
      11'd256, 11'd1024, 11'd256, 11'd128, 11'd51, 11'd13, 11'd0
   };

endpackage

[sv/gradient_feather_pixel_shader_core.sv]
// Channel  Ports                                   Direction  Word
// request  req_valid, req_ready, req_data          in         one pixel: column, row, masks
// response rsp_valid, rsp_ready, rsp_data          out        one shaded pixel: red, green, blue
// config   csr_wr_en, csr_index, csr_wdata         in         one register write, no read-back
//
// One pixel per clock is accepted while the pipeline has room; each pixel passes through the
// five register stages (centering and mask distances, rotation products, weight and gain,
// blend, gain and saturation). Reset is synchronous and clears the stage valid bits and loads
// the register defaults. A stalled response holds its stage; earlier stages keep moving into
// any empty slot, so the request side stays ready until the pipeline is full.
module gradient_feather_pixel_shader_core #(
   parameter int COLUMNS = 20,
   parameter int ROWS    = 149
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  gfps_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output gfps_pkg::rsp_type                   rsp_data,
   input  logic                                csr_wr_en,
   input  logic [gfps_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [gfps_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int STAGES = 5;

   // Configuration registers.
   logic [7:0]         start_red_ff, start_green_ff, start_blue_ff;
   logic [7:0]         end_red_ff, end_green_ff, end_blue_ff;
   logic signed [15:0] rot_cos_ff, rot_sin_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_red_ff   <= 8'd100;
         start_green_ff <= 8'd2;
         start_blue_ff  <= 8'd20;
         end_red_ff     <= 8'd10;
         end_green_ff   <= 8'd2;
         end_blue_ff    <= 8'd80;
         rot_cos_ff     <= 16'sd32767;
         rot_sin_ff     <= 16'sd0;
      end else if (csr_wr_en) begin
         unique case (gfps_pkg::csr_index_type'(csr_index))
            gfps_pkg::CSR_START_RED:   start_red_ff   <= csr_wdata[7:0];
            gfps_pkg::CSR_START_GREEN: start_green_ff <= csr_wdata[7:0];
            gfps_pkg::CSR_START_BLUE:  start_blue_ff  <= csr_wdata[7:0];
            gfps_pkg::CSR_END_RED:     end_red_ff     <= csr_wdata[7:0];
            gfps_pkg::CSR_END_GREEN:   end_green_ff   <= csr_wdata[7:0];
            gfps_pkg::CSR_END_BLUE:    end_blue_ff    <= csr_wdata[7:0];
            gfps_pkg::CSR_ROT_COS:     rot_cos_ff     <= $signed(csr_wdata);
            gfps_pkg::CSR_ROT_SIN:     rot_sin_ff     <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // Stage flow control: a stage takes a new word whenever it is empty or its word moves on.
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] rdy;

   always_comb begin
      rdy[STAGES-1] = !valid_ff[STAGES-1] || rsp_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
      valid_in[0] = rdy[0] ? req_valid : valid_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = rdy[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = rdy[0];
   assign rsp_valid = valid_ff[STAGES-1];

   // Centering tables: floor(column * 65536 / COLUMNS) and floor(row * 65536 / ROWS).
   logic [20:0] col_tab [32];
   logic [20:0] row_tab [256];

   for (genvar i = 0; i < 32; i++) begin : g_col_tab
      assign col_tab[i] = 21'((i * 65536) / COLUMNS);
   end
   for (genvar i = 0; i < 256; i++) begin : g_row_tab
      assign row_tab[i] = 21'((i * 65536) / ROWS);
   end

   // Stage 0: centered coordinates and signed mask distances in Q8.8.
   logic signed [21:0] x_in, x_ff, y_in, y_ff;
   logic signed [17:0] dl_in, dl_ff, dh_in, dh_ff;

   assign x_in  = $signed({1'b0, col_tab[req_data.column]}) - 22'sd32768;
   assign y_in  = $signed({1'b0, row_tab[req_data.row]}) - 22'sd32768;
   assign dl_in = $signed({2'b0, req_data.mask_low}) - $signed({2'b0, req_data.row, 8'b0});
   assign dh_in = $signed({2'b0, req_data.row, 8'b0}) - $signed({2'b0, req_data.mask_high});

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         x_ff  <= x_in;
         y_ff  <= y_in;
         dl_ff <= dl_in;
         dh_ff <= dh_in;
      end
   end

   // Stage 1: rotation products and the feather decision.
   logic signed [37:0] px_in, px_ff, py_in, py_ff;
   logic               black_in, black_ff;
   logic               feather_in, feather_ff;
   logic [2:0]         idx_in, idx_ff;
   logic [7:0]         frac_in, frac_ff;
   logic signed [17:0] feather_dist;

   assign px_in = x_ff * rot_sin_ff;
   assign py_in = y_ff * rot_cos_ff;

   always_comb begin
      black_in     = (dl_ff >= 18'sd1280) || (dh_ff >= 18'sd1280);
      feather_in   = (dl_ff > 18'sd0) || (dh_ff > 18'sd0);
      // The lower mask wins when the pixel is past both.
      feather_dist = (dl_ff > 18'sd0) ? dl_ff : dh_ff;
      idx_in       = (feather_dist[10:8] > 3'(gfps_pkg::FEATHER_LAST)) ?
                     3'(gfps_pkg::FEATHER_LAST) : feather_dist[10:8];
      frac_in      = feather_dist[7:0];
   end

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         px_ff      <= px_in;
         py_ff      <= py_in;
         black_ff   <= black_in;
         feather_ff <= feather_in;
         idx_ff     <= idx_in;
         frac_ff    <= frac_in;
      end
   end

   // Stage 2: blend weight and gain.
   logic signed [38:0] rot_sum;
   logic signed [24:0] weight_pre;
   logic [16:0]        weight_in, weight_ff;
   logic [19:0]        gain_sum;
   logic [10:0]        gain_in, gain_ff;

   always_comb begin
      rot_sum    = {px_ff[37], px_ff} + {py_ff[37], py_ff};
      // Taking the upper bits is a floor shift by fifteen.
      weight_pre = {rot_sum[38], rot_sum[38:15]} + 25'sd32768;
      if (weight_pre[24]) begin
         weight_in = '0;
      end else if (weight_pre > $signed({8'b0, gfps_pkg::WEIGHT_ONE})) begin
         weight_in = gfps_pkg::WEIGHT_ONE;
      end else begin
         weight_in = weight_pre[16:0];
      end
   end

   always_comb begin
      gain_sum = 20'(frac_ff) * 20'(gfps_pkg::GAIN_TABLE[idx_ff + 3'd1])
               + 20'(9'd256 - {1'b0, frac_ff}) * 20'(gfps_pkg::GAIN_TABLE[idx_ff]);
      if (black_ff) begin
         gain_in = '0;
      end else if (feather_ff) begin
         gain_in = gain_sum[18:8];
      end else begin
         gain_in = gfps_pkg::GAIN_UNITY;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         weight_ff <= weight_in;
         gain_ff   <= gain_in;
      end
   end

   // Stage 3 carries the gain beside the blended colors.
   logic [10:0] gain_dly_ff;

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         gain_dly_ff <= gain_ff;
      end
   end

   // Stages 3 and 4 live in the color channels.
   gfps_pkg::adv_type adv;

   assign adv.blend = rdy[3];
   assign adv.out   = rdy[4];

   gfps_channel u_red (
      .clock       (clock),
      .adv         (adv),
      .start_color (start_red_ff),
      .end_color   (end_red_ff),
      .weight      (weight_ff),
      .gain        (gain_dly_ff),
      .color       (rsp_data.red)
   );

   gfps_channel u_green (
      .clock       (clock),
      .adv         (adv),
      .start_color (start_green_ff),
      .end_color   (end_green_ff),
      .weight      (weight_ff),
      .gain        (gain_dly_ff),
      .color       (rsp_data.green)
   );

   gfps_channel u_blue (
      .clock       (clock),
      .adv         (adv),
      .start_color (start_blue_ff),
      .end_color   (end_blue_ff),
      .weight      (weight_ff),
      .gain        (gain_dly_ff),
      .color       (rsp_data.blue)
   );

`ifndef SYNTH
   // Words in flight change only by what enters and what leaves.
   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ($countones(valid_ff) == $past($countones(valid_ff))
                + int'($past(req_valid && req_ready)) - int'($past(rsp_valid && rsp_ready))))
      else $error("pipeline occupancy does not match the handshakes");

   a_weight_clamp: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] |-> (weight_ff <= gfps_pkg::WEIGHT_ONE))
      else $error("blend weight above one");

   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff[2] |-> (gain_ff <= 11'd1024))
      else $error("gain above the table peak");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[3] && !rdy[4]) |=> (valid_ff[3] && $stable(gain_dly_ff)))
      else $error("blend stage lost its word during a stall");
`endif

endmodule

[sv/gfps_channel.sv]
module gfps_channel (
   input  logic             clock,
   input  gfps_pkg::adv_type adv,
   input  logic [7:0]       start_color,
   input  logic [7:0]       end_color,
   input  logic [16:0]      weight,
   input  logic [10:0]      gain,
   output logic [7:0]       color
);

   logic signed [8:0]  diff;
   logic signed [27:0] blend_sum;
   logic [7:0]         blend_in;
   logic [7:0]         blend_ff;
   logic [18:0]        gain_prod;
   logic [10:0]        scaled;
   logic [7:0]         color_in;
   logic [7:0]         color_ff;

   // The weighted sum never goes negative since the weight stays within zero and one.
   assign diff      = $signed({1'b0, end_color}) - $signed({1'b0, start_color});
   assign blend_sum = $signed({4'b0, start_color, 16'b0}) + $signed({1'b0, weight}) * diff;
   assign blend_in  = blend_sum[23:16];

   assign gain_prod = blend_ff * gain;
   assign scaled    = gain_prod[18:8];
   assign color_in  = (scaled > 11'd255) ? 8'hFF : scaled[7:0];

   always_ff @(posedge clock) begin
      if (adv.blend) begin
         blend_ff <= blend_in;
      end
      if (adv.out) begin
         color_ff <= color_in;
      end
   end

   assign color = color_ff;

endmodule

[tb/sv/tb_gradient_feather_pixel_shader_core.sv]
`timescale 1ns / 100ps

module tb_gradient_feather_pixel_shader_core;

   localparam int PANEL_COLUMNS  = 20;
   localparam int PANEL_ROWS     = 149;
   localparam int FEATHER_SPAN_Q = 1280;
   localparam int STALL_LIMIT    = 4000;
   localparam int HOLDOFF_CYCLES = 200;
   localparam int DRAIN_CYCLES   = 10;
   localparam int PRINT_LIMIT    = 100;

   // Feather gains in Q3.8, one entry per row of distance past the mask.
   localparam int FEATHER_GAIN [7] = '{256, 1024, 256, 128, 51, 13, 0};

   logic                             clock     = 1'b0;
   logic                             reset     = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   gfps_pkg::req_type                req_data  = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   gfps_pkg::rsp_type                rsp_data;
   logic                             csr_wr_en = 1'b0;
   logic [gfps_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [gfps_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // Shadow copy of the shader registers.
   logic [7:0]         color_start [3];
   logic [7:0]         color_end [3];
   logic signed [15:0] rot_cos_q;
   logic signed [15:0] rot_sin_q;

   gfps_pkg::req_type raster_queue [$];
   gfps_pkg::rsp_type shaded_pixels [$];

   int   send_idle_pct    = 0;
   int   recv_stall_pct   = 0;
   int   holdoff_requests = 0;
   int   holdoff_served   = 0;
   int   holdoff_left     = 0;
   logic req_fire         = 1'b0;
   int   error_count      = 0;
   int   stall_cycles     = 0;

   gradient_feather_pixel_shader_core #(
      .COLUMNS(PANEL_COLUMNS),
      .ROWS   (PANEL_ROWS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic gfps_pkg::rsp_type shade_pixel(gfps_pkg::req_type px);
      longint            x, y, w, dl, dh, d, f, idx, gain, t;
      longint            chan [3];
      int                i;
      gfps_pkg::rsp_type res;
      x = (longint'(px.column) * 65536) / PANEL_COLUMNS - 32768;
      y = (longint'(px.row) * 65536) / PANEL_ROWS - 32768;
      // Arithmetic shift of a signed value rounds toward minus infinity.
      w = ((x * longint'(rot_sin_q) + y * longint'(rot_cos_q)) >>> 15) + 32768;
      if (w < 0) w = 0;
      if (w > 65536) w = 65536;
      for (i = 0; i < 3; i++) begin
         t = longint'(color_start[i]) * 65536
             + w * (longint'(color_end[i]) - longint'(color_start[i]));
         if (t < 0) t = 0;
         chan[i] = t >> 16;
      end
      dl = longint'(px.mask_low) - longint'(px.row) * 256;
      dh = longint'(px.row) * 256 - longint'(px.mask_high);
      if (dh >= FEATHER_SPAN_Q || dl >= FEATHER_SPAN_Q) begin
         for (i = 0; i < 3; i++) chan[i] = 0;
      end else begin
         d = 0;
         if (dl > 0) d = dl;
         else if (dh > 0) d = dh;
         if (d > 0) begin
            idx = d >> 8;
            if (idx > 4) idx = 4;
            f = d & 255;
            gain = (f * FEATHER_GAIN[idx + 1] + (256 - f) * FEATHER_GAIN[idx]) >> 8;
            for (i = 0; i < 3; i++) begin
               t = (chan[i] * gain) >> 8;
               chan[i] = (t > 255) ? 255 : t;
            end
         end
      end
      res.red   = chan[0][7:0];
      res.green = chan[1][7:0];
      res.blue  = chan[2][7:0];
      return res;
   endfunction

   function automatic int clip16(int v);
      if (v < 0) return 0;
      if (v > 65535) return 65535;
      return v;
   endfunction

   function automatic gfps_pkg::req_type make_req(int col, int row, int lo, int hi);
      gfps_pkg::req_type px;
      px.column    = col[4:0];
      px.row       = row[7:0];
      px.mask_low  = lo[15:0];
      px.mask_high = hi[15:0];
      return px;
   endfunction

   // Mostly pixels on the panel; the masks land inside, in the feather band or beyond it.
   function automatic gfps_pkg::req_type random_pixel();
      int col, row, base, lo, hi;
      col  = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 31) : $urandom_range(0, 19);
      row  = ($urandom_range(0, 7) == 0) ? $urandom_range(149, 255) : $urandom_range(0, 148);
      base = row * 256;
      case ($urandom_range(0, 9)) inside
         [0:2]: begin
            lo = $urandom_range(0, base);
            hi = $urandom_range(base, 65535);
         end
         [3:4]: begin
            lo = clip16(base + $urandom_range(1, 1279));
            hi = $urandom_range(0, 65535);
         end
         5: begin
            lo = $urandom_range(0, base);
            hi = clip16(base - $urandom_range(1, 1279));
         end
         6: begin
            lo = clip16(base + $urandom_range(1, 1279));
            hi = clip16(base - $urandom_range(1, 1279));
         end
         7: begin
            if ($urandom_range(0, 1) == 1) begin
               lo = clip16(base + $urandom_range(1280, 6000));
               hi = $urandom_range(0, 65535);
            end else begin
               lo = $urandom_range(0, base);
               hi = clip16(base - $urandom_range(1280, 6000));
            end
         end
         default: begin
            lo = $urandom_range(0, 65535);
            hi = $urandom_range(0, 65535);
         end
      endcase
      return make_req(col, row, lo, hi);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      if (error_count < PRINT_LIMIT)
         $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   // Sender: holds a word until it is taken, then offers the next one or idles.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (raster_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_data  <= raster_queue.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever one is requested.
   always @(negedge clock) begin
      if (holdoff_left > 0) begin
         rsp_ready    <= 1'b0;
         holdoff_left <= holdoff_left - 1;
      end else if (holdoff_requests != holdoff_served) begin
         rsp_ready      <= 1'b0;
         holdoff_served <= holdoff_served + 1;
         holdoff_left   <= HOLDOFF_CYCLES;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin : monitor
      gfps_pkg::rsp_type want;
      if (reset) begin
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (shaded_pixels.size() == 0) begin
               report_mismatch("pixel with none pending", int'(rsp_data), 0);
            end else begin
               want = shaded_pixels.pop_front();
               if (rsp_data.red !== want.red)
                  report_mismatch("red", int'(rsp_data.red), int'(want.red));
               if (rsp_data.green !== want.green)
                  report_mismatch("green", int'(rsp_data.green), int'(want.green));
               if (rsp_data.blue !== want.blue)
                  report_mismatch("blue", int'(rsp_data.blue), int'(want.blue));
            end
         end
         if (req_valid && req_ready) shaded_pixels.push_back(shade_pixel(req_data));
      end
   end

   // Counts cycles without any accepted word while work is outstanding.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (raster_queue.size() == 0 && shaded_pixels.size() == 0 && !req_valid)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Called at a falling edge; the write lands on the next rising edge.
   task automatic csr_write(gfps_pkg::csr_index_type idx, logic [15:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         gfps_pkg::CSR_START_RED:   color_start[0] = value[7:0];
         gfps_pkg::CSR_START_GREEN: color_start[1] = value[7:0];
         gfps_pkg::CSR_START_BLUE:  color_start[2] = value[7:0];
         gfps_pkg::CSR_END_RED:     color_end[0]   = value[7:0];
         gfps_pkg::CSR_END_GREEN:   color_end[1]   = value[7:0];
         gfps_pkg::CSR_END_BLUE:    color_end[2]   = value[7:0];
         gfps_pkg::CSR_ROT_COS:     rot_cos_q      = value;
         gfps_pkg::CSR_ROT_SIN:     rot_sin_q      = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Color registers get junk in their upper byte, which must be dropped.
   task automatic load_registers(int sr, int sg, int sb, int er, int eg, int eb,
                                 logic [15:0] cos_q, logic [15:0] sin_q);
      csr_write(gfps_pkg::CSR_START_RED,   {8'($urandom_range(0, 255)), 8'(sr)});
      csr_write(gfps_pkg::CSR_START_GREEN, {8'($urandom_range(0, 255)), 8'(sg)});
      csr_write(gfps_pkg::CSR_START_BLUE,  {8'($urandom_range(0, 255)), 8'(sb)});
      csr_write(gfps_pkg::CSR_END_RED,     {8'($urandom_range(0, 255)), 8'(er)});
      csr_write(gfps_pkg::CSR_END_GREEN,   {8'($urandom_range(0, 255)), 8'(eg)});
      csr_write(gfps_pkg::CSR_END_BLUE,    {8'($urandom_range(0, 255)), 8'(eb)});
      csr_write(gfps_pkg::CSR_ROT_COS, cos_q);
      csr_write(gfps_pkg::CSR_ROT_SIN, sin_q);
      csr_wr_en <= 1'b0;
   endtask

   task automatic load_random_registers();
      load_registers($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
   endtask

   // Corners of the panel and of the feather band.
   task automatic push_directed();
      raster_queue.push_back(make_req(0, 0, 0, 0));
      raster_queue.push_back(make_req(19, 148, 37888, 37888));
      raster_queue.push_back(make_req(31, 255, 0, 65535));
      raster_queue.push_back(make_req(19, 0, 0, 65535));
      raster_queue.push_back(make_req(0, 148, 0, 65535));
      raster_queue.push_back(make_req(20, 149, 0, 65535));
      raster_queue.push_back(make_req(0, 0, 65535, 0));
      raster_queue.push_back(make_req(10, 100, 25601, 65535));
      raster_queue.push_back(make_req(10, 100, 25855, 65535));
      raster_queue.push_back(make_req(10, 100, 25856, 65535));
      raster_queue.push_back(make_req(10, 100, 26879, 65535));
      raster_queue.push_back(make_req(10, 100, 26880, 65535));
      raster_queue.push_back(make_req(5, 50, 0, 12799));
      raster_queue.push_back(make_req(5, 50, 0, 11521));
      raster_queue.push_back(make_req(5, 50, 0, 11520));
      raster_queue.push_back(make_req(5, 50, 13100, 12100));
      raster_queue.push_back(make_req(5, 50, 14800, 12700));
      raster_queue.push_back(make_req(7, 74, 0, 0));
      raster_queue.push_back(make_req(7, 74, 65535, 65535));
      raster_queue.push_back(make_req(31, 0, 0, 65535));
   endtask

   task automatic wait_drained();
      while (raster_queue.size() != 0 || req_valid || shaded_pixels.size() != 0)
         @(negedge clock);
   endtask

   task automatic run_phase(int send_pct, int recv_pct, bit directed, int count, bit holdoff);
      send_idle_pct  = send_pct;
      recv_stall_pct = recv_pct;
      if (directed) push_directed();
      repeat (count) raster_queue.push_back(random_pixel());
      if (holdoff) holdoff_requests++;
      wait_drained();
   endtask

   initial begin
      color_start = '{8'd100, 8'd2, 8'd20};
      color_end   = '{8'd10, 8'd2, 8'd80};
      rot_cos_q   = 16'sd32767;
      rot_sin_q   = 16'sd0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_phase(0, 0, 1'b1, 80, 1'b0);

      load_registers(255, 255, 255, 0, 0, 0, 16'h8000, 16'h7FFF);
      run_phase(50, 0, 1'b1, 100, 1'b0);

      load_registers(0, 0, 0, 255, 255, 255, 16'h7FFF, 16'h8000);
      run_phase(0, 50, 1'b0, 120, 1'b0);

      load_random_registers();
      run_phase(14, 14, 1'b0, 140, 1'b0);

      load_random_registers();
      run_phase(0, 0, 1'b0, 150, 1'b1);

      load_registers(255, 0, 128, 0, 255, 128, 16'h0000, 16'h7FFF);
      run_phase(14, 14, 1'b0, 120, 1'b0);

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

[sim.f]
sv/gfps_pkg.sv
sv/gfps_channel.sv
sv/gradient_feather_pixel_shader_core.sv
tb/sv/tb_gradient_feather_pixel_shader_core.sv
